>>> rtl/tcc_pkg.sv
// Shared constants and types for the text console cursor engine.
// Holds grid geometry, character codes, command codes and the cell layout.
// Depends on nothing.
`default_nettype none

package tcc_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ADDR_W   = $clog2(CELLS);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int CURSOR_W = 11;
  localparam int FUNC_W   = 2;
  localparam int BYTE_W   = 8;

  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;
  localparam int COPY_CELLS    = CELLS - COLUMNS;

  localparam logic [BYTE_W-1:0] COLOR_DEFAULT = 8'h07;
  localparam logic [BYTE_W-1:0] CH_NEWLINE    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE  = 8'h08;
  localparam logic [BYTE_W-1:0] CH_BLANK      = 8'h20;

  localparam logic [FUNC_W-1:0] FUNC_PRINT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] color;
    logic [BYTE_W-1:0] ch;
  } cell_t;

endpackage

`default_nettype wire

>>> rtl/text_console_cursor_engine.sv
// Text console engine: character grid in one synchronous cell memory,
// cursor tracking, scroll and clear sweeps, cell read-back.
// Depends on tcc_pkg.
`default_nettype none

// Channel  | Direction | Handshake           | Word
// ---------+-----------+---------------------+---------------------------------------
// in_      | input     | in_valid/in_ready   | func, char_code, cell_index
// out_     | output    | out_valid/out_ready | cursor_position, cell_char, cell_color,
//          |           |                     | scrolled
// cfg_     | input     | cfg_valid/cfg_ready | text_color (always ready)
//
// Steps: a printed character, newline, backspace, no-op or a read past the
// grid end is accepted, then its result goes into the output register; a
// read inside the grid passes through an extra state for the memory read.
// A scroll walks the cell memory once: it copies COLUMNS*(ROWS-1) cells one
// row up, then blanks the COLUMNS cells of the bottom row. A clear blanks
// every cell.
// Reset homes the cursor and restores colour 7; cell contents stay unknown.
// The input is held off while an item is in flight; a stalled output word
// holds the engine in its result state, while a waiting word does not stop
// the next item being taken.

module text_console_cursor_engine (
  input  wire                                clk,
  input  wire                                rst_n,
  // command channel
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [tcc_pkg::FUNC_W-1:0]         in_func,
  input  wire  [tcc_pkg::BYTE_W-1:0]         in_char_code,
  input  wire  [tcc_pkg::CURSOR_W-1:0]       in_cell_index,
  // result channel
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [tcc_pkg::CURSOR_W-1:0]       out_cursor_position,
  output logic [tcc_pkg::BYTE_W-1:0]         out_cell_char,
  output logic [tcc_pkg::BYTE_W-1:0]         out_cell_color,
  output logic                               out_scrolled,
  // colour register write
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [tcc_pkg::BYTE_W-1:0]         cfg_text_color
);

  import tcc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_COPY  = 3'd2;
  localparam logic [2:0] S_BLANK = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  // Control state
  logic [2:0]        state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [BYTE_W-1:0] color_r, color_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              cp_v_r, cp_v_nxt;
  logic [ADDR_W-1:0] cp_addr_r, cp_addr_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Pending result fields
  logic [BYTE_W-1:0] res_char_r, res_char_nxt;
  logic [BYTE_W-1:0] res_color_r, res_color_nxt;
  logic              res_scr_r, res_scr_nxt;

  // Output word
  logic [CURSOR_W-1:0] out_pos_r;
  logic [BYTE_W-1:0]   out_char_r;
  logic [BYTE_W-1:0]   out_color_r;
  logic                out_scr_r;

  // Cell memory ports
  cell_t             mem [CELLS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  cell_t             mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  cell_t             mem_rdata_r;

  logic in_acc;
  logic out_load;
  logic go_scroll;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_pos_r;
  assign out_cell_char       = out_char_r;
  assign out_cell_color      = out_color_r;
  assign out_scrolled        = out_scr_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pos_nxt       = pos_r;
    color_nxt     = color_r;
    cnt_nxt       = cnt_r;
    cp_v_nxt      = cp_v_r;
    cp_addr_nxt   = cp_addr_r;
    res_char_nxt  = res_char_r;
    res_color_nxt = res_color_r;
    res_scr_nxt   = res_scr_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    out_load      = 1'b0;
    go_scroll     = 1'b0;

    if (cfg_valid && cfg_ready) begin
      color_nxt = cfg_text_color;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_char_nxt  = '0;
          res_color_nxt = '0;
          res_scr_nxt   = 1'b0;
          state_nxt     = S_EMIT;
          case (in_func)
            FUNC_PRINT: begin
              if (in_char_code == CH_NEWLINE) begin
                col_nxt = '0;
                if (row_r == ROW_W'(ROWS - 1)) begin
                  go_scroll = 1'b1;
                end else begin
                  row_nxt = row_r + 1'b1;
                  pos_nxt = ADDR_W'(pos_r - ADDR_W'(col_r) + ADDR_W'(COLUMNS));
                end
              end else if (in_char_code == CH_BACKSPACE) begin
                // blank the cell behind the cursor; column zero is left alone
                if (col_r != '0) begin
                  col_nxt   = col_r - 1'b1;
                  pos_nxt   = pos_r - 1'b1;
                  mem_we    = 1'b1;
                  mem_waddr = pos_r - 1'b1;
                  mem_wdata = '{color: color_r, ch: CH_BLANK};
                end
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pos_r;
                mem_wdata = '{color: color_r, ch: in_char_code};
                if (col_r == COL_W'(COLUMNS - 1)) begin
                  col_nxt = '0;
                  if (row_r == ROW_W'(ROWS - 1)) begin
                    go_scroll = 1'b1;
                  end else begin
                    row_nxt = row_r + 1'b1;
                    pos_nxt = pos_r + 1'b1;
                  end
                end else begin
                  col_nxt = col_r + 1'b1;
                  pos_nxt = pos_r + 1'b1;
                end
              end
              // passing the last row: cursor parks at the start of the bottom line
              if (go_scroll) begin
                res_scr_nxt = 1'b1;
                pos_nxt     = ADDR_W'(LAST_ROW_BASE);
                cnt_nxt     = '0;
                cp_v_nxt    = 1'b0;
                state_nxt   = S_COPY;
              end
            end
            FUNC_CLEAR: begin
              color_nxt = COLOR_DEFAULT;
              col_nxt   = '0;
              row_nxt   = '0;
              pos_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_BLANK;
            end
            FUNC_READ: begin
              // out-of-range index reports zero cell fields
              if (in_cell_index < CURSOR_W'(CELLS)) begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(in_cell_index);
                state_nxt = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_char_nxt  = mem_rdata_r.ch;
        res_color_nxt = mem_rdata_r.color;
        state_nxt     = S_EMIT;
      end
      S_COPY: begin
        // write back the cell read last cycle one row up
        if (cp_v_r) begin
          mem_we    = 1'b1;
          mem_waddr = cp_addr_r;
          mem_wdata = mem_rdata_r;
        end
        if (cnt_r < ADDR_W'(COPY_CELLS)) begin
          mem_re      = 1'b1;
          mem_raddr   = ADDR_W'(cnt_r + ADDR_W'(COLUMNS));
          cp_v_nxt    = 1'b1;
          cp_addr_nxt = cnt_r;
          cnt_nxt     = cnt_r + 1'b1;
        end else begin
          cp_v_nxt  = 1'b0;
          cnt_nxt   = ADDR_W'(COPY_CELLS);
          state_nxt = S_BLANK;
        end
      end
      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = '{color: color_r, ch: CH_BLANK};
        if (cnt_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EMIT: begin
        // hand the word over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      pos_r       <= '0;
      color_r     <= COLOR_DEFAULT;
      cnt_r       <= '0;
      cp_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pos_r       <= pos_nxt;
      color_r     <= color_nxt;
      cnt_r       <= cnt_nxt;
      cp_v_r      <= cp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r   <= cp_addr_nxt;
    res_char_r  <= res_char_nxt;
    res_color_r <= res_color_nxt;
    res_scr_r   <= res_scr_nxt;
    if (out_load) begin
      out_pos_r   <= CURSOR_W'(pos_r);
      out_char_r  <= res_char_r;
      out_color_r <= res_color_r;
      out_scr_r   <= res_scr_r;
    end
  end

  // Linear position tracks column and row between items
  a_pos_track: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      (32'(pos_r) == 32'(row_r) * COLUMNS + 32'(col_r)))
    else $error("cursor position out of step with column and row");

  // Column never reaches the row end
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < COLUMNS))
    else $error("cursor column out of range");

  // A scrolled result leaves the cursor at the start of the bottom line
  a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && res_scr_r) |->
      (row_r == ROW_W'(ROWS - 1) && col_r == '0))
    else $error("scroll left cursor off the bottom line");

  // Cell writes in idle come only from an accepted print word
  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == S_IDLE) |-> (in_acc && in_func == FUNC_PRINT))
    else $error("cell write in idle without a print word");

endmodule

`default_nettype wire

>>> tb/sv/console_grid_checker.sv
// Passive checker for the text console cursor engine: keeps its own grid,
// cursor and pen colour, predicts each result word and compares it.
// Depends on tcc_pkg.
module console_grid_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [tcc_pkg::FUNC_W-1:0]   in_func,
  input  logic [tcc_pkg::BYTE_W-1:0]   in_char_code,
  input  logic [tcc_pkg::CURSOR_W-1:0] in_cell_index,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [tcc_pkg::CURSOR_W-1:0] out_cursor_position,
  input  logic [tcc_pkg::BYTE_W-1:0]   out_cell_char,
  input  logic [tcc_pkg::BYTE_W-1:0]   out_cell_color,
  input  logic                         out_scrolled,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [tcc_pkg::BYTE_W-1:0]   cfg_text_color,
  output int                           fail_count,
  output int                           pending_words,
  output int                           scroll_count
);

  import tcc_pkg::*;

  typedef struct {
    logic [CURSOR_W-1:0] cursor;
    logic [BYTE_W-1:0]   ch;
    logic [BYTE_W-1:0]   colour;
    logic                scrolled;
  } console_reply_t;

  cell_t          screen [CELLS];
  int             cur_col;
  int             cur_row;
  logic [7:0]     pen_colour;
  console_reply_t cursor_replies [$];

  // Apply one command word to the grid and return the word it should produce.
  function automatic console_reply_t apply_command(input logic [FUNC_W-1:0] func,
                                                   input logic [BYTE_W-1:0] ch,
                                                   input logic [CURSOR_W-1:0] idx);
    console_reply_t reply;
    reply = '{default: '0};
    if (func == FUNC_PRINT) begin
      if (ch == CH_NEWLINE) begin
        cur_row++;
        cur_col = 0;
      end else if (ch == CH_BACKSPACE) begin
        if (cur_col != 0) begin
          cur_col--;
          screen[cur_row * COLUMNS + cur_col] = {pen_colour, CH_BLANK};
        end
      end else begin
        screen[cur_row * COLUMNS + cur_col] = {pen_colour, ch};
        cur_col++;
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
      end
      // past the last row: move everything up a line, blank the bottom one
      if (cur_row >= ROWS) begin
        for (int i = 0; i < COPY_CELLS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = LAST_ROW_BASE; i < CELLS; i++) screen[i] = {pen_colour, CH_BLANK};
        cur_row = ROWS - 1;
        reply.scrolled = 1'b1;
      end
    end else if (func == FUNC_CLEAR) begin
      pen_colour = COLOR_DEFAULT;
      for (int i = 0; i < CELLS; i++) screen[i] = {pen_colour, CH_BLANK};
      cur_col = 0;
      cur_row = 0;
    end else if (func == FUNC_READ) begin
      if (idx < CELLS) begin
        reply.ch     = screen[idx].ch;
        reply.colour = screen[idx].color;
      end
    end
    reply.cursor = CURSOR_W'(cur_row * COLUMNS + cur_col);
    return reply;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    console_reply_t want;
    if (!rst_n) begin
      cur_col       = 0;
      cur_row       = 0;
      pen_colour    = COLOR_DEFAULT;
      fail_count    = 0;
      scroll_count  = 0;
      cursor_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) pen_colour = cfg_text_color;
      if (in_valid && in_ready)
        cursor_replies.push_back(apply_command(in_func, in_char_code, in_cell_index));
      if (out_valid && out_ready) begin
        if (cursor_replies.size() == 0) begin
          $display("%0t: unexpected result word, cursor %0d", $time, out_cursor_position);
          fail_count++;
        end else begin
          want = cursor_replies.pop_front();
          check_field("cursor_position", want.cursor, out_cursor_position);
          check_field("cell_char", want.ch, out_cell_char);
          check_field("cell_color", want.colour, out_cell_color);
          check_field("scrolled", want.scrolled, out_scrolled);
          if (out_scrolled === 1'b1) scroll_count++;
        end
      end
    end
    pending_words = cursor_replies.size();
  end

endmodule

>>> tb/sv/tb_text_console_cursor_engine.sv
// Top of the text console engine testbench: clock, reset, command and
// colour stimulus, result back-pressure and the verdict.
// Depends on tcc_pkg, console_grid_checker and text_console_cursor_engine.
module tb_text_console_cursor_engine;
  import tcc_pkg::*;

  // Spare command code: the engine must only report the cursor for it.
  localparam logic [FUNC_W-1:0] FUNC_IDLE = 2'd3;
  localparam int RANDOM_WORDS  = 1200;
  localparam int PHASES        = 5;
  // Longest single command is a scroll sweep.
  localparam int SETTLE_CYCLES = 2100;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  wire                 in_ready;
  logic [FUNC_W-1:0]   in_func;
  logic [BYTE_W-1:0]   in_char_code;
  logic [CURSOR_W-1:0] in_cell_index;
  wire                 out_valid;
  logic                out_ready;
  wire [CURSOR_W-1:0]  out_cursor_position;
  wire [BYTE_W-1:0]    out_cell_char;
  wire [BYTE_W-1:0]    out_cell_color;
  wire                 out_scrolled;
  logic                cfg_valid;
  wire                 cfg_ready;
  logic [BYTE_W-1:0]   cfg_text_color;

  int fail_count;
  int pending_words;
  int scroll_count;

  int words_sent;
  int reads_sent;
  int clears_sent;
  int colours_set;
  bit send_calm;   // when set, the sender puts no gaps between words
  bit sink_calm;   // when set, the result side never stalls

  text_console_cursor_engine u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_char_code        (in_char_code),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cursor_position (out_cursor_position),
    .out_cell_char       (out_cell_char),
    .out_cell_color      (out_cell_color),
    .out_scrolled        (out_scrolled),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_text_color      (cfg_text_color)
  );

  console_grid_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_char_code        (in_char_code),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cursor_position (out_cursor_position),
    .out_cell_char       (out_cell_char),
    .out_cell_color      (out_cell_color),
    .out_scrolled        (out_scrolled),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_text_color      (cfg_text_color),
    .fail_count          (fail_count),
    .pending_words       (pending_words),
    .scroll_count        (scroll_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Hang guard: sized for every word being a full scroll sweep with the
  // longest gaps and stalls, several times over.
  initial begin : watchdog
    #100_000_000;
    $display("tb_text_console_cursor_engine: errors");
    $finish;
  end

  // Result side: after each accepted word, hold ready low for a random
  // number of cycles, with occasional stretches of no stalling at all.
  initial begin : result_sink
    int unsigned hold;
    hold      = 0;
    sink_calm = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
        hold = sink_calm ? 0 : $urandom_range(0, 19);
      end
    end
  end

  // Present one command word after a random gap and hold it until taken.
  task automatic send_word(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] ch,
                           input logic [CURSOR_W-1:0] idx);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_char_code  <= ch;
    in_cell_index <= idx;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (func == FUNC_READ) reads_sent++;
    if (func == FUNC_CLEAR) clears_sent++;
  endtask

  // Drop valid and hold off until every predicted word has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
  endtask

  // Colour writes only go in while the engine has nothing in flight.
  task automatic write_colour(input logic [BYTE_W-1:0] colour);
    drain_results();
    cfg_valid      <= 1'b1;
    cfg_text_color <= colour;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    colours_set++;
  endtask

  task automatic read_cell(input int idx);
    send_word(FUNC_READ, 8'($urandom), CURSOR_W'(idx));
  endtask

  // One burst of random traffic, mostly shaped like real console output.
  task automatic run_sequence();
    int unsigned pick;
    send_calm = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // a line of text; long ones wrap, most end in a newline
      repeat ($urandom_range(0, 100))
        send_word(FUNC_PRINT, 8'($urandom), CURSOR_W'($urandom));
      if ($urandom_range(0, 3) != 0)
        send_word(FUNC_PRINT, CH_NEWLINE, CURSOR_W'($urandom));
    end else if (pick < 65) begin
      // blank lines push the cursor down into scrolling
      repeat ($urandom_range(1, 20))
        send_word(FUNC_PRINT, CH_NEWLINE, CURSOR_W'($urandom));
    end else if (pick < 73) begin
      repeat ($urandom_range(1, 12))
        send_word(FUNC_PRINT, CH_BACKSPACE, CURSOR_W'($urandom));
    end else if (pick < 88) begin
      // reads land mostly on the grid, now and then past its end
      repeat ($urandom_range(1, 6))
        read_cell(($urandom_range(0, 9) == 0) ? $urandom_range(CELLS, 2047)
                                              : $urandom_range(0, CELLS - 1));
    end else if (pick < 91) begin
      send_word(FUNC_CLEAR, 8'($urandom), CURSOR_W'($urandom));
    end else if (pick < 94) begin
      drain_results();
    end else begin
      // noise: any code, any byte, any index
      repeat ($urandom_range(1, 4))
        send_word(2'($urandom), 8'($urandom), CURSOR_W'($urandom));
    end
  endtask

  initial begin : stimulus
    int phase_end;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FUNC_PRINT;
    in_char_code   = '0;
    in_cell_index  = '0;
    cfg_valid      = 1'b0;
    cfg_text_color = COLOR_DEFAULT;
    words_sent     = 0;
    reads_sent     = 0;
    clears_sent    = 0;
    colours_set    = 0;
    send_calm      = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Clear first: the grid holds nothing readable until then.
    send_word(FUNC_CLEAR, 8'h00, 11'h000);
    write_colour(8'hFF);
    send_word(FUNC_PRINT, 8'h00, 11'h7FF);
    send_word(FUNC_PRINT, 8'hFF, 11'h000);
    send_word(FUNC_PRINT, 8'h41, 11'h000);
    for (int i = 0; i < 3; i++) read_cell(i);
    // backspace blanks the cell it steps back onto
    send_word(FUNC_PRINT, CH_BACKSPACE, 11'h000);
    read_cell(2);
    send_word(FUNC_PRINT, CH_NEWLINE, 11'h000);
    // backspace in column zero must leave everything alone
    send_word(FUNC_PRINT, CH_BACKSPACE, 11'h000);
    read_cell(CELLS - 1);
    read_cell(CELLS);
    read_cell(2047);
    send_word(FUNC_IDLE, 8'hFF, 11'h7FF);
    // clear brings the colour back to its default
    send_word(FUNC_CLEAR, 8'hFF, 11'h7FF);
    send_word(FUNC_PRINT, 8'h5A, 11'h000);
    read_cell(0);

    // Random part, one colour setting per phase, extremes first.
    phase_end = words_sent;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       write_colour(8'h00);
        1:       write_colour(8'hFF);
        default: write_colour(8'($urandom));
      endcase
      phase_end += RANDOM_WORDS / PHASES;
      while (words_sent < phase_end) run_sequence();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("tb: %0d command words sent, %0d reads and %0d clears among them", words_sent,
             reads_sent, clears_sent);
    $display("tb: %0d scrolls seen across %0d colour settings", scroll_count, colours_set);
    if (fail_count == 0 && pending_words == 0) begin
      $display("tb_text_console_cursor_engine: clean");
    end else begin
      $display("tb_text_console_cursor_engine: errors");
    end
    $finish;
  end

endmodule
